// ===== sv/keyframe_move_sequencer_top_assert.svh =====
// ---------------------------------------------------------------------------
// keyframe move sequencer assertion macros
// shared property forms for the sequencer checks
// ---------------------------------------------------------------------------
`ifndef KEYFRAME_MOVE_SEQUENCER_TOP_ASSERT_SVH
`define KEYFRAME_MOVE_SEQUENCER_TOP_ASSERT_SVH

// condition that must hold at every edge out of reset
`define KMS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define KMS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/kms_pkg.sv =====
// ---------------------------------------------------------------------------
// kms_pkg
// types, constants and helpers of the keyframe move sequencer
// ---------------------------------------------------------------------------
package kms_pkg;

  localparam int PROG_DEPTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = $clog2(PROG_DEPTH);
  localparam int PASS_W     = $clog2(PROG_DEPTH + 2);
  localparam int STEP_W     = 32 + PASS_W;
  localparam int DIV_STEPS  = 33;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [1:0] OP_END   = 2'd0;
  localparam logic [1:0] OP_PLACE = 2'd1;
  localparam logic [1:0] OP_MOVE  = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        frames;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } prog_entry_t;

  localparam int ENTRY_W = $bits(prog_entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_READ,
    S_DIV,
    S_APPLY,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/kms_in_if.sv =====
// ---------------------------------------------------------------------------
// kms_in_if
// input channel: program writes and frame ticks
// ---------------------------------------------------------------------------
interface kms_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [3:0]         entry_index;
  logic [1:0]         opcode;
  logic [15:0]        frame_count;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;

  modport source (
    output valid, mode, entry_index, opcode, frame_count, target_x, target_y, target_z,
    input  ready
  );
  modport sink (
    input  valid, mode, entry_index, opcode, frame_count, target_x, target_y, target_z,
    output ready
  );
endinterface

// ===== sv/kms_out_if.sv =====
// ---------------------------------------------------------------------------
// kms_out_if
// result channel: one result per frame tick
// ---------------------------------------------------------------------------
interface kms_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] step_x;
  logic signed [31:0] step_y;
  logic signed [31:0] step_z;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [3:0]         entry_now;
  logic [4:0]         passes;
  logic               fault;

  modport source (
    output valid, step_x, step_y, step_z, pos_x, pos_y, pos_z, entry_now, passes, fault,
    input  ready
  );
  modport sink (
    input  valid, step_x, step_y, step_z, pos_x, pos_y, pos_z, entry_now, passes, fault,
    output ready
  );
endinterface

// ===== sv/keyframe_move_sequencer_top.sv =====
// ---------------------------------------------------------------------------
// keyframe_move_sequencer_top
// motion program sequencer: stores entries, steps a 3-axis position per tick
// ---------------------------------------------------------------------------
//
// channel   dir  handshake            payload
// in_ch     in   valid / ready        mode, entry_index, opcode, frame_count, target_x/y/z
// out_ch    out  valid / ready        step_x/y/z, pos_x/y/z, entry_now, passes, fault
//
// a program write is taken while idle and gives no result
// a tick runs passes: a running move takes pass and apply; a fetch takes pass, read
//   (read again on a wrap), the divider wait for a move, and apply; done posts the result
// the serial divider (one quotient bit a cycle, all axes at once) sets the cost
// reset is synchronous active low; program kinds read as end via valid bits
// a finished result waits in the output register; new writes are still taken
// a tick that finds the output register full holds until it drains
//
module keyframe_move_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  kms_in_if.sink      in_ch,
  kms_out_if.source   out_ch
);

  `include "keyframe_move_sequencer_top_assert.svh"

  kms_pkg::seq_state_t state_r, state_nxt;

  // program store and per-entry kind valid bits
  logic [kms_pkg::IDX_W-1:0]   rd_addr;
  logic                        rd_en;
  logic [kms_pkg::ENTRY_W-1:0] rd_data;
  logic                        wr_en;
  logic [kms_pkg::IDX_W-1:0]   wr_addr;
  kms_pkg::prog_entry_t        wr_entry;
  kms_pkg::prog_entry_t        ent;
  logic [kms_pkg::PROG_DEPTH-1:0] kind_vld_r, kind_vld_nxt;

  // sequencer state
  logic                         started_r, started_nxt;
  logic [kms_pkg::IDX_W-1:0]    cursor_r, cursor_nxt;
  logic [kms_pkg::IDX_W-1:0]    fetch_idx_r, fetch_idx_nxt;
  logic [15:0]                  frames_left_r, frames_left_nxt;
  logic                         mv_ready_r, mv_ready_nxt;
  logic [kms_pkg::PASS_W-1:0]   passes_r, passes_nxt;
  logic                         fault_r, fault_nxt;
  logic signed [31:0]           delta_r [3];
  logic signed [31:0]           delta_nxt [3];
  logic signed [31:0]           cur_r [3];
  logic signed [31:0]           cur_nxt [3];
  logic signed [kms_pkg::STEP_W-1:0] step_r [3];
  logic signed [kms_pkg::STEP_W-1:0] step_nxt [3];

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic signed [31:0]           out_step_r [3];
  logic signed [31:0]           out_step_nxt [3];
  logic signed [31:0]           out_pos_r [3];
  logic signed [31:0]           out_pos_nxt [3];
  logic [3:0]                   out_entry_r, out_entry_nxt;
  logic [4:0]                   out_passes_r, out_passes_nxt;
  logic                         out_fault_r, out_fault_nxt;

  // divider hookup
  logic                         div_start;
  logic signed [32:0]           div_num [3];
  logic [15:0]                  div_den;
  logic signed [33:0]           div_quot [3];
  kms_pkg::div_status_t         div_st;

  // fetch decode
  logic                         tick_xfer;
  logic                         wr_xfer;
  logic                         out_xfer;
  logic [kms_pkg::IDX_W:0]      next_idx;
  logic [kms_pkg::IDX_W-1:0]    fetch_idx;
  logic [1:0]                   kind_eff;
  logic                         kind_is_op;
  logic signed [31:0]           tgt [3];
  logic                         at_limit;
  logic                         out_free;

  assign in_ch.ready = (state_r == kms_pkg::S_IDLE);
  assign tick_xfer   = in_ch.valid && in_ch.ready && in_ch.mode;
  assign wr_xfer     = in_ch.valid && in_ch.ready && !in_ch.mode;
  assign out_xfer    = out_valid_r && out_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // program writes: out-of-range indices are dropped; writes only land while idle,
  // so reads of a tick never overlap a write
  assign wr_en            = wr_xfer && (32'(in_ch.entry_index) < kms_pkg::PROG_DEPTH);
  assign wr_addr          = kms_pkg::IDX_W'(in_ch.entry_index);
  assign wr_entry.kind    = in_ch.opcode;
  assign wr_entry.frames  = in_ch.frame_count;
  assign wr_entry.tx      = in_ch.target_x;
  assign wr_entry.ty      = in_ch.target_y;
  assign wr_entry.tz      = in_ch.target_z;

  kms_ram #(
    .WIDTH (kms_pkg::ENTRY_W),
    .DEPTH (kms_pkg::PROG_DEPTH)
  ) u_prog_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign ent    = kms_pkg::prog_entry_t'(rd_data);
  assign tgt[0] = ent.tx;
  assign tgt[1] = ent.ty;
  assign tgt[2] = ent.tz;

  // an entry never written still reads as end of program
  assign kind_eff   = kind_vld_r[fetch_idx_r] ? ent.kind : kms_pkg::OP_END;
  assign kind_is_op = (kind_eff == kms_pkg::OP_PLACE) || (kind_eff == kms_pkg::OP_MOVE);

  // next fetch: entry 0 first after reset, then cursor+1 wrapping at the table end
  assign next_idx  = {1'b0, cursor_r} + 1'b1;
  assign fetch_idx = !started_r ? '0 :
                     (32'(next_idx) >= kms_pkg::PROG_DEPTH) ? '0 :
                     kms_pkg::IDX_W'(next_idx);
  assign at_limit  = (32'(passes_r) >= kms_pkg::PROG_DEPTH + 1);

  assign div_den = (ent.frames == 16'd0) ? 16'd1 : ent.frames;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      div_num[a] = 33'(tgt[a]) - 33'(cur_r[a]);
    end
  end

  kms_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .quot   (div_quot),
    .status (div_st)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kms_pkg::S_IDLE: begin
        if (tick_xfer) begin
          state_nxt = kms_pkg::S_PASS;
        end
      end
      kms_pkg::S_PASS: begin
        if (at_limit) begin
          state_nxt = kms_pkg::S_DONE;
        end else if (frames_left_r != 16'd0) begin
          state_nxt = kms_pkg::S_APPLY;
        end else begin
          state_nxt = kms_pkg::S_READ;
        end
      end
      kms_pkg::S_READ: begin
        if (!kind_is_op && (fetch_idx_r != '0)) begin
          state_nxt = kms_pkg::S_READ;
        end else if (kind_eff == kms_pkg::OP_MOVE) begin
          state_nxt = kms_pkg::S_DIV;
        end else begin
          state_nxt = kms_pkg::S_APPLY;
        end
      end
      kms_pkg::S_DIV: begin
        if (div_st.done) begin
          state_nxt = kms_pkg::S_APPLY;
        end
      end
      kms_pkg::S_APPLY: begin
        state_nxt = mv_ready_r ? kms_pkg::S_DONE : kms_pkg::S_PASS;
      end
      kms_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = kms_pkg::S_IDLE;
        end
      end
      default: state_nxt = kms_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_vld_nxt    = kind_vld_r;
    started_nxt     = started_r;
    cursor_nxt      = cursor_r;
    fetch_idx_nxt   = fetch_idx_r;
    frames_left_nxt = frames_left_r;
    mv_ready_nxt    = mv_ready_r;
    passes_nxt      = passes_r;
    fault_nxt       = fault_r;
    rd_en           = 1'b0;
    rd_addr         = fetch_idx;
    div_start       = 1'b0;
    out_valid_nxt   = out_valid_r && !out_xfer;
    out_entry_nxt   = out_entry_r;
    out_passes_nxt  = out_passes_r;
    out_fault_nxt   = out_fault_r;
    for (int a = 0; a < 3; a++) begin
      delta_nxt[a]    = delta_r[a];
      cur_nxt[a]      = cur_r[a];
      step_nxt[a]     = step_r[a];
      out_step_nxt[a] = out_step_r[a];
      out_pos_nxt[a]  = out_pos_r[a];
    end

    if (wr_en) begin
      kind_vld_nxt[wr_addr] = 1'b1;
    end

    unique case (state_r)
      kms_pkg::S_IDLE: begin
        if (tick_xfer) begin
          passes_nxt   = '0;
          fault_nxt    = 1'b0;
          mv_ready_nxt = 1'b0;
          for (int a = 0; a < 3; a++) begin
            step_nxt[a] = '0;
          end
        end
      end
      kms_pkg::S_PASS: begin
        if (at_limit) begin
          fault_nxt = 1'b1;
        end else if (frames_left_r != 16'd0) begin
          // move still running: reuse its delta
          mv_ready_nxt = 1'b1;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = fetch_idx;
          fetch_idx_nxt = fetch_idx;
          started_nxt   = 1'b1;
        end
      end
      kms_pkg::S_READ: begin
        if (!kind_is_op && (fetch_idx_r != '0)) begin
          // end of program: wrap and fetch entry 0
          rd_en         = 1'b1;
          rd_addr       = '0;
          fetch_idx_nxt = '0;
        end else begin
          cursor_nxt = fetch_idx_r;
          if (kind_eff == kms_pkg::OP_PLACE) begin
            frames_left_nxt = 16'd1;
            mv_ready_nxt    = 1'b0;
            for (int a = 0; a < 3; a++) begin
              delta_nxt[a] = kms_pkg::sat32(64'(tgt[a]) - 64'(cur_r[a]));
            end
          end else if (kind_eff == kms_pkg::OP_MOVE) begin
            div_start       = 1'b1;
            frames_left_nxt = div_den;
            mv_ready_nxt    = 1'b1;
          end else begin
            // entry 0 is itself an end: the pass moves nothing
            mv_ready_nxt = 1'b0;
            for (int a = 0; a < 3; a++) begin
              delta_nxt[a] = '0;
            end
          end
        end
      end
      kms_pkg::S_DIV: begin
        if (div_st.done) begin
          for (int a = 0; a < 3; a++) begin
            delta_nxt[a] = kms_pkg::sat32(64'(div_quot[a]));
          end
        end
      end
      kms_pkg::S_APPLY: begin
        for (int a = 0; a < 3; a++) begin
          cur_nxt[a]  = kms_pkg::sat32(64'(cur_r[a]) + 64'(delta_r[a]));
          step_nxt[a] = step_r[a] + kms_pkg::STEP_W'(delta_r[a]);
        end
        if (frames_left_r != 16'd0) begin
          frames_left_nxt = frames_left_r - 16'd1;
        end
        passes_nxt = passes_r + 1'b1;
      end
      kms_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_entry_nxt  = 4'(cursor_r);
          out_passes_nxt = 5'(passes_r);
          out_fault_nxt  = fault_r;
          for (int a = 0; a < 3; a++) begin
            out_step_nxt[a] = kms_pkg::sat32(64'(step_r[a]));
            out_pos_nxt[a]  = cur_r[a];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= kms_pkg::S_IDLE;
      kind_vld_r    <= '0;
      started_r     <= 1'b0;
      cursor_r      <= '0;
      fetch_idx_r   <= '0;
      frames_left_r <= '0;
      mv_ready_r    <= 1'b0;
      passes_r      <= '0;
      fault_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        delta_r[a] <= '0;
        cur_r[a]   <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      kind_vld_r    <= kind_vld_nxt;
      started_r     <= started_nxt;
      cursor_r      <= cursor_nxt;
      fetch_idx_r   <= fetch_idx_nxt;
      frames_left_r <= frames_left_nxt;
      mv_ready_r    <= mv_ready_nxt;
      passes_r      <= passes_nxt;
      fault_r       <= fault_nxt;
      out_valid_r   <= out_valid_nxt;
      for (int a = 0; a < 3; a++) begin
        delta_r[a] <= delta_nxt[a];
        cur_r[a]   <= cur_nxt[a];
      end
    end
    out_entry_r  <= out_entry_nxt;
    out_passes_r <= out_passes_nxt;
    out_fault_r  <= out_fault_nxt;
    for (int a = 0; a < 3; a++) begin
      step_r[a]     <= step_nxt[a];
      out_step_r[a] <= out_step_nxt[a];
      out_pos_r[a]  <= out_pos_nxt[a];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.step_x    = out_step_r[0];
  assign out_ch.step_y    = out_step_r[1];
  assign out_ch.step_z    = out_step_r[2];
  assign out_ch.pos_x     = out_pos_r[0];
  assign out_ch.pos_y     = out_pos_r[1];
  assign out_ch.pos_z     = out_pos_r[2];
  assign out_ch.entry_now = out_entry_r;
  assign out_ch.passes    = out_passes_r;
  assign out_ch.fault     = out_fault_r;

  // pass count never runs past the limit
  `KMS_ASSERT_ALWAYS(a_pass_bound, 32'(passes_r) <= kms_pkg::PROG_DEPTH + 1, "pass count over limit")
  // the divider only runs while the sequencer waits on it
  `KMS_ASSERT_IMPL(a_div_owner, div_st.busy, state_r == kms_pkg::S_DIV, "divider busy outside div")
  // a fault result always reports a full pass budget
  `KMS_ASSERT_IMPL(a_fault_passes, out_valid_r && out_fault_r,
    32'(out_passes_r) == ((kms_pkg::PROG_DEPTH + 1) % 32), "fault without full pass count")
  // a move fetch always leaves frames to run
  `KMS_ASSERT_NEXT(a_move_frames, div_start, frames_left_r != 16'd0, "move loaded zero frames")

endmodule

// ===== sv/kms_ram.sv =====
// ---------------------------------------------------------------------------
// kms_ram
// generic single-write, single-read ram with registered read
// ---------------------------------------------------------------------------
module kms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/kms_div.sv =====
// ---------------------------------------------------------------------------
// kms_div
// three-lane restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module kms_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [32:0]     num [3],
  input  logic [15:0]            den,
  output logic signed [33:0]     quot [3],
  output kms_pkg::div_status_t   status
);

  logic [32:0]                  mag_r [3];
  logic [32:0]                  mag_nxt [3];
  logic [15:0]                  rem_r [3];
  logic [15:0]                  rem_nxt [3];
  logic [32:0]                  quo_r [3];
  logic [32:0]                  quo_nxt [3];
  logic [2:0]                   neg_r;
  logic [2:0]                   neg_nxt;
  logic [15:0]                  den_r;
  logic [15:0]                  den_nxt;
  logic [kms_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [kms_pkg::DIV_CNT_W-1:0] cnt_nxt;
  logic                         busy_r;
  logic                         busy_nxt;
  logic                         done_r;
  logic                         done_nxt;
  logic [16:0]                  shifted [3];
  logic [16:0]                  diff [3];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    for (int a = 0; a < 3; a++) begin
      mag_nxt[a] = mag_r[a];
      rem_nxt[a] = rem_r[a];
      quo_nxt[a] = quo_r[a];
      shifted[a] = {rem_r[a], mag_r[a][32]};
      diff[a]    = shifted[a] - {1'b0, den_r};
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = den;
      for (int a = 0; a < 3; a++) begin
        neg_nxt[a] = num[a][32];
        mag_nxt[a] = num[a][32] ? 33'(-num[a]) : 33'(num[a]);
        rem_nxt[a] = '0;
        quo_nxt[a] = '0;
      end
    end else if (busy_r) begin
      for (int a = 0; a < 3; a++) begin
        mag_nxt[a] = {mag_r[a][31:0], 1'b0};
        if (!diff[a][16]) begin
          rem_nxt[a] = diff[a][15:0];
          quo_nxt[a] = {quo_r[a][31:0], 1'b1};
        end else begin
          rem_nxt[a] = shifted[a][15:0];
          quo_nxt[a] = {quo_r[a][31:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == kms_pkg::DIV_CNT_W'(kms_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    for (int a = 0; a < 3; a++) begin
      mag_r[a] <= mag_nxt[a];
      rem_r[a] <= rem_nxt[a];
      quo_r[a] <= quo_nxt[a];
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      quot[a] = neg_r[a] ? -$signed({1'b0, quo_r[a]}) : $signed({1'b0, quo_r[a]});
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule
